// ===== hdl/mvfs_pkg.sv =====
package mvfs_pkg;

    localparam logic [7:0] CODE_PICTURE  = 8'h00;
    localparam logic [7:0] CODE_SLICE_LO = 8'h01;
    localparam logic [7:0] CODE_SLICE_HI = 8'hAF;
    localparam logic [7:0] CODE_SEQ_HDR  = 8'hB3;
    localparam logic [7:0] CODE_EXT      = 8'hB5;

    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_MPEG1   = 2'd1;
    localparam logic [1:0] KIND_MPEG2   = 2'd2;

    // start code prefix 00 00 01 as it sits in the three older history bytes
    localparam logic [23:0] START_PREFIX = 24'h000001;
    localparam logic [2:0]  PIC_TYPE_I   = 3'd1;
    localparam logic [1:0]  PIC_TYPE_DELAY = 2'd2;

    typedef struct packed {
        logic       start_code_seen;
        logic [7:0] start_code_value;
        logic       frame_boundary;
        logic       frame_was_key;
        logic [1:0] codec_kind;
    } t_result;

endpackage

// ===== hdl/mpeg_video_frame_splitter.sv =====
// MPEG-1/MPEG-2 video frame splitter. Takes one elementary stream byte per
// transaction and returns one result per byte: whether the byte completes a
// start code (00 00 01 xx) and its code, whether the previous frame ended just
// before that start code and if it held an I picture, and the codec kind found
// so far. The parser state advances in the cycle a byte is accepted; its result
// goes to the output register, or to the skid register while the output is
// held, so one byte is taken every clock while the output side keeps up. This
// two-entry output stage lets the input keep flowing while a result waits;
// o_stall is registered and rises only when both entries hold results.
module mpeg_video_frame_splitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_start_code_seen,
    output logic [7:0] o_start_code_value,
    output logic       o_frame_boundary,
    output logic       o_frame_was_key,
    output logic [1:0] o_codec_kind
);

    logic              accept;
    logic              out_free;
    mvfs_pkg::t_result core_res;

    logic              r_out_valid;
    logic              r_skid_valid;
    mvfs_pkg::t_result r_out;
    mvfs_pkg::t_result r_skid;

    assign accept   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    mvfs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_result    (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            // output held: park the new result
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : core_res;
        end else if (accept) begin
            r_skid <= core_res;
        end
    end

    assign o_stall            = r_skid_valid;
    assign o_valid            = r_out_valid;
    assign o_start_code_seen  = r_out.start_code_seen;
    assign o_start_code_value = r_out.start_code_value;
    assign o_frame_boundary   = r_out.frame_boundary;
    assign o_frame_was_key    = r_out.frame_was_key;
    assign o_codec_kind       = r_out.codec_kind;

endmodule

// ===== hdl/mvfs_core.sv =====
module mvfs_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    output mvfs_pkg::t_result  o_result
);

    logic [23:0] r_hist, n_hist;
    logic        r_in_frame, n_in_frame;
    logic        r_seen_seq, n_seen_seq;
    logic [1:0]  r_kind, n_kind;
    logic        r_key, n_key;
    logic [1:0]  r_cd, n_cd;

    logic        hit;
    logic        is_slice;
    logic        key_mid;
    logic [1:0]  cd_dec;

    always_comb begin
        hit      = (r_hist == mvfs_pkg::START_PREFIX);
        is_slice = i_data_byte inside {[mvfs_pkg::CODE_SLICE_LO : mvfs_pkg::CODE_SLICE_HI]};

        // coding type sits in bits 5..3 of the second byte after the picture code
        key_mid = r_key | ((r_cd == 2'd1) && (i_data_byte[5:3] == mvfs_pkg::PIC_TYPE_I));
        cd_dec  = (r_cd != 2'd0) ? r_cd - 2'd1 : r_cd;

        n_hist     = {r_hist[15:0], i_data_byte};
        n_in_frame = r_in_frame;
        n_seen_seq = r_seen_seq;
        n_kind     = r_kind;
        n_key      = key_mid;
        n_cd       = cd_dec;

        o_result = '0;

        if (hit) begin
            o_result.start_code_seen  = 1'b1;
            o_result.start_code_value = i_data_byte;
            n_hist = '1;

            if (i_data_byte == mvfs_pkg::CODE_SEQ_HDR) begin
                n_seen_seq = 1'b1;
            end else if (i_data_byte == mvfs_pkg::CODE_EXT) begin
                n_kind = mvfs_pkg::KIND_MPEG2;
            end else if (i_data_byte == mvfs_pkg::CODE_PICTURE && r_seen_seq &&
                         r_kind == mvfs_pkg::KIND_UNKNOWN) begin
                n_kind = mvfs_pkg::KIND_MPEG1;
            end

            if (is_slice) begin
                n_in_frame = 1'b1;
            end else if (r_in_frame) begin
                // close the frame and report its key flag
                n_in_frame = 1'b0;
                o_result.frame_boundary = 1'b1;
                o_result.frame_was_key  = key_mid;
                n_key = 1'b0;
            end

            if (i_data_byte == mvfs_pkg::CODE_PICTURE) begin
                n_cd = mvfs_pkg::PIC_TYPE_DELAY;
            end
        end

        o_result.codec_kind = n_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= '1;
            r_in_frame <= 1'b0;
            r_seen_seq <= 1'b0;
            r_kind     <= mvfs_pkg::KIND_UNKNOWN;
            r_key      <= 1'b0;
            r_cd       <= 2'd0;
        end else if (i_accept) begin
            r_hist     <= n_hist;
            r_in_frame <= n_in_frame;
            r_seen_seq <= n_seen_seq;
            r_kind     <= n_kind;
            r_key      <= n_key;
            r_cd       <= n_cd;
        end
    end

endmodule

// ===== hdl/mvfs_checker.sv =====
module mvfs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_start_code_seen,
    input logic [7:0] o_start_code_value,
    input logic       o_frame_boundary,
    input logic       o_frame_was_key,
    input logic [1:0] o_codec_kind
);

    a_value_zero_without_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_start_code_seen |-> o_start_code_value == 8'h00)
        else $error("code value set without a start code");

    a_boundary_needs_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_boundary |-> o_start_code_seen &&
        (o_start_code_value == mvfs_pkg::CODE_PICTURE ||
         o_start_code_value > mvfs_pkg::CODE_SLICE_HI))
        else $error("frame boundary on a slice code or without a start code");

    a_key_needs_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_was_key |-> o_frame_boundary)
        else $error("key flag without a frame boundary");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_codec_kind != 2'b11)
        else $error("illegal codec kind");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_start_code_value) &&
        $stable(o_start_code_seen))
        else $error("result changed while stalled");

endmodule

bind mpeg_video_frame_splitter mvfs_checker u_mvfs_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_start_code_seen  (o_start_code_seen),
    .o_start_code_value (o_start_code_value),
    .o_frame_boundary   (o_frame_boundary),
    .o_frame_was_key    (o_frame_was_key),
    .o_codec_kind       (o_codec_kind)
);

// ===== dv/tb_mpeg_video_frame_splitter.sv =====
`timescale 1ns / 100ps

module tb_mpeg_video_frame_splitter;

    localparam int BYTE_TARGET  = 1400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_AT      = 600;
    localparam int DRAIN_AT     = 900;
    localparam int SETTLE_TICKS = 8;

    // Tracks the stream parser state and keeps the results it implies, oldest first.
    class frame_split_scoreboard;
        logic [31:0]       history;
        bit                in_frame;
        bit                seen_seq;
        bit                key_pending;
        logic [1:0]        kind;
        logic [1:0]        type_countdown;
        mvfs_pkg::t_result want_q[$];
        int                errors;
        int                n_bytes;

        function new();
            history        = '1;
            in_frame       = 1'b0;
            seen_seq       = 1'b0;
            key_pending    = 1'b0;
            kind           = mvfs_pkg::KIND_UNKNOWN;
            type_countdown = '0;
            errors         = 0;
            n_bytes        = 0;
        endfunction

        function void note_byte(logic [7:0] b);
            mvfs_pkg::t_result r;
            bit                is_slice;
            r = '0;
            // coding type sits in the second byte after the picture code
            if (type_countdown != 0) begin
                if (type_countdown == 2'd1 && b[5:3] == mvfs_pkg::PIC_TYPE_I)
                    key_pending = 1'b1;
                type_countdown = type_countdown - 2'd1;
            end
            history = {history[23:0], b};
            if (history[31:8] == mvfs_pkg::START_PREFIX) begin
                r.start_code_seen  = 1'b1;
                r.start_code_value = b;
                history = '1;
                if (b == mvfs_pkg::CODE_SEQ_HDR)
                    seen_seq = 1'b1;
                else if (b == mvfs_pkg::CODE_EXT)
                    kind = mvfs_pkg::KIND_MPEG2;
                else if (b == mvfs_pkg::CODE_PICTURE && seen_seq &&
                         kind == mvfs_pkg::KIND_UNKNOWN)
                    kind = mvfs_pkg::KIND_MPEG1;
                is_slice = (b >= mvfs_pkg::CODE_SLICE_LO) && (b <= mvfs_pkg::CODE_SLICE_HI);
                if (is_slice) begin
                    in_frame = 1'b1;
                end else if (in_frame) begin
                    in_frame          = 1'b0;
                    r.frame_boundary  = 1'b1;
                    r.frame_was_key   = key_pending;
                    key_pending       = 1'b0;
                end
                if (b == mvfs_pkg::CODE_PICTURE)
                    type_countdown = mvfs_pkg::PIC_TYPE_DELAY;
            end
            r.codec_kind = kind;
            want_q.push_back(r);
            n_bytes++;
        endfunction

        function void check_result(mvfs_pkg::t_result got);
            mvfs_pkg::t_result want;
            if (want_q.size() == 0) begin
                $error("result with no transaction pending: %h", got);
                errors++;
                return;
            end
            want = want_q.pop_front();
            if (got.start_code_seen !== want.start_code_seen) begin
                $error("start_code_seen: expected %0d, got %0d",
                       want.start_code_seen, got.start_code_seen);
                errors++;
            end
            if (got.start_code_value !== want.start_code_value) begin
                $error("start_code_value: expected %0h, got %0h",
                       want.start_code_value, got.start_code_value);
                errors++;
            end
            if (got.frame_boundary !== want.frame_boundary) begin
                $error("frame_boundary: expected %0d, got %0d",
                       want.frame_boundary, got.frame_boundary);
                errors++;
            end
            if (got.frame_was_key !== want.frame_was_key) begin
                $error("frame_was_key: expected %0d, got %0d",
                       want.frame_was_key, got.frame_was_key);
                errors++;
            end
            if (got.codec_kind !== want.codec_kind) begin
                $error("codec_kind: expected %0d, got %0d",
                       want.codec_kind, got.codec_kind);
                errors++;
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic [7:0]        i_data_byte = 8'h00;
    logic              i_stall     = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic              o_start_code_seen;
    logic [7:0]        o_start_code_value;
    logic              o_frame_boundary;
    logic              o_frame_was_key;
    logic [1:0]        o_codec_kind;
    mvfs_pkg::t_result dut_result;

    frame_split_scoreboard sb;
    int cycle_count;
    int tx_quiet;
    int rx_quiet;
    int rx_hold;
    bit long_hold_done;
    bit drained;

    mpeg_video_frame_splitter i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_data_byte        (i_data_byte),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_start_code_seen  (o_start_code_seen),
        .o_start_code_value (o_start_code_value),
        .o_frame_boundary   (o_frame_boundary),
        .o_frame_was_key    (o_frame_was_key),
        .o_codec_kind       (o_codec_kind)
    );

    assign dut_result = {o_start_code_seen, o_start_code_value, o_frame_boundary,
                         o_frame_was_key, o_codec_kind};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("mpeg_video_frame_splitter verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(dut_result);
    end

    // Output side backpressure: short stalls, occasional long ones, quiet stretches,
    // and one long hold so the block fills up and stalls the stream.
    initial begin
        int r;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && sb != null && sb.n_bytes >= HOLD_AT) begin
                long_hold_done = 1'b1;
                rx_quiet       = 0;
                rx_hold        = LONG_HOLD;
            end
            if (rx_quiet > 0) begin
                rx_quiet--;
                i_stall <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold--;
                i_stall <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    i_stall <= 1'b0;
                end else if (r < 75) begin
                    rx_quiet = $urandom_range(30, 80);
                    i_stall <= 1'b0;
                end else if (r < 95) begin
                    rx_hold = $urandom_range(0, 2);
                    i_stall <= 1'b1;
                end else begin
                    rx_hold = $urandom_range(8, 30);
                    i_stall <= 1'b1;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_quiet > 0) begin
            tx_quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 93) begin
            tx_quiet = $urandom_range(30, 90);
            return 0;
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid     <= 1'b0;
            i_data_byte <= 8'($urandom);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        // hold the byte until the block takes it
        do
            @(posedge i_clk);
        while (o_stall);
        sb.note_byte(b);
    endtask

    task automatic put_start_code(input logic [7:0] code);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h01);
        put_byte(code);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic put_picture_header();
        logic [7:0] coding;
        put_start_code(mvfs_pkg::CODE_PICTURE);
        put_byte(8'($urandom));
        coding = 8'($urandom);
        coding[5:3] = $urandom_range(0, 1) ? mvfs_pkg::PIC_TYPE_I : 3'($urandom_range(0, 7));
        put_byte(coding);
    endtask

    task automatic put_random_chunk();
        int         r;
        int         n;
        logic [7:0] code;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            case ($urandom_range(0, 9))
                0, 1, 2: code = mvfs_pkg::CODE_PICTURE;
                3, 4, 5: code = 8'($urandom_range(mvfs_pkg::CODE_SLICE_LO,
                                                  mvfs_pkg::CODE_SLICE_HI));
                6:       code = mvfs_pkg::CODE_SEQ_HDR;
                7:       code = mvfs_pkg::CODE_EXT;
                default: code = 8'($urandom_range(8'hB0, 8'hFF));
            endcase
            if (code == mvfs_pkg::CODE_PICTURE)
                put_picture_header();
            else
                put_start_code(code);
            n = $urandom_range(0, 6);
            repeat (n)
                put_byte(8'($urandom));
        end else if (r < 90) begin
            // noise, heavy on zero bytes
            n = $urandom_range(1, 8);
            repeat (n)
                put_byte($urandom_range(0, 2) == 0 ? 8'h00 : 8'($urandom));
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    put_byte(8'h00);
                    put_byte(8'h00);
                    put_byte(8'($urandom));
                end
                1: begin
                    put_byte(8'h00);
                    put_start_code(8'($urandom));
                end
                default: begin
                    // new start code lands before the coding type byte
                    put_start_code(mvfs_pkg::CODE_PICTURE);
                    put_start_code(8'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        sb = new();
        repeat (11)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // picture before any sequence header, I type
        put_start_code(mvfs_pkg::CODE_PICTURE);
        put_byte(8'hFF);
        put_byte({2'b00, mvfs_pkg::PIC_TYPE_I, 3'b000});
        put_start_code(mvfs_pkg::CODE_SEQ_HDR);
        put_start_code(mvfs_pkg::CODE_SLICE_LO);
        // picture closes the keyed frame; reserved coding type follows
        put_start_code(mvfs_pkg::CODE_PICTURE);
        put_byte(8'h00);
        put_byte({2'b00, 3'd7, 3'b000});
        put_start_code(mvfs_pkg::CODE_SLICE_HI);
        put_start_code(mvfs_pkg::CODE_EXT);

        while (sb.n_bytes < BYTE_TARGET) begin
            put_random_chunk();
            if (!drained && sb.n_bytes >= DRAIN_AT) begin
                drained = 1'b1;
                wait_drain();
            end
        end

        wait_drain();
        repeat (SETTLE_TICKS)
            @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("mpeg_video_frame_splitter verification clean");
        else
            $display("mpeg_video_frame_splitter verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mvfs_pkg.sv
hdl/mvfs_core.sv
hdl/mpeg_video_frame_splitter.sv
hdl/mvfs_checker.sv
dv/tb_mpeg_video_frame_splitter.sv
